// ----- rtl/sws_pkg.sv -----
// sws_pkg: shared types and constants for the sliding-window sender
// item kinds, register indexes, sequencer states and the result record
// no dependencies
package sws_pkg;

  localparam int WIN_DEPTH   = 64;
  localparam int PAYLOAD_MAX = 1024;
  localparam int SLOT_W      = $clog2(WIN_DEPTH);
  localparam int CNT_W       = 7;
  localparam int SEQ_W       = 32;
  localparam int PAY_W       = 10;
  localparam int ACKB_W      = 16;
  localparam int TOTAL_W     = 48;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 120;
  localparam int OUT_USER_W  = 3;

  localparam logic [CNT_W-1:0]  WINDOW_RESET  = CNT_W'(45);
  localparam logic [31:0]       TIMEOUT_RESET = 32'd1000;
  localparam logic [CNT_W-1:0]  LIMIT_RESET   = CNT_W'(2);
  localparam logic [PAY_W-1:0]  PAY_LIMIT     = PAY_W'(PAYLOAD_MAX - 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT     = CNT_W'(WIN_DEPTH);

  typedef enum logic [1:0] {
    KIND_NEW  = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_GAP  = 2'd2,
    KIND_TICK = 2'd3
  } kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WINDOW  = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_LIMIT   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_USE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                 send_valid;
    logic [SEQ_W-1:0]     send_seq;
    logic                 is_resend;
    logic [PAY_W-1:0]     send_bytes;
    logic                 refused;
    logic [ACKB_W-1:0]    acked_bytes;
    logic [TOTAL_W-1:0]   total_sent_bytes;
    logic [CNT_W-1:0]     in_flight_count;
    logic                 transfer_done;
    logic                 last;
  } res_t;

endpackage

// ----- rtl/sliding_window_sender_core.sv -----
// sliding_window_sender_core: sender side of a selective-repeat sliding window
// holds the slot length memory and the walk sequencer
// depends on sws_pkg and sws_total_acc
//
// usage
//   in_*  : one transaction per command; in_tuser is the kind (new packet,
//           cumulative ack, gap range, tick), in_tlast marks the final packet
//           of the source, in_tdata carries the length and sequence numbers
//   out_* : one transaction per packet transmission, or a single status
//           transaction when a command sends nothing; out_tlast closes the
//           results of one command
//   cfg_* : register writes (window size, timeout, resend limit), always ready
// sequencing
//   in_tready is high only while the sequencer is idle, one command at a time
//   new packet: the execute state loads the result into the output register once
//   the output is free, then the sequencer returns to idle for the next command
//   ack, gap, timeout: the walk visits n slots (at most 64), each through a read
//   state and then a use state on the single read port of the slot memory; the
//   final result goes out from the finish state after the walk
// reset: synchronous, active low; window empty, counters and total cleared,
//   registers back to 45, 1000 and 2; slot memory is not cleared
// stalls: one output register plus one held resend; when out_tready stays low
//   the walk stops at the next result it must hand over, nothing is dropped
module sliding_window_sender_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input command channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [9:0] payload_bytes, [41:10] ack_upto, [73:42] gap_start,
  // [105:74] gap_end, [111:106] zero
  input  logic [sws_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [1:0]                     in_tuser,
  input  logic                           in_tlast,
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] send_seq, [41:32] send_bytes, [57:42] acked_bytes,
  // [105:58] total_sent_bytes, [112:106] in_flight_count,
  // [113] transfer_done, [119:114] zero
  output logic [sws_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] send_valid, [1] is_resend, [2] refused
  output logic [sws_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                           out_tlast,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sws_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sws_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sws_pkg::*;

  // configuration registers
  logic [CNT_W-1:0]   window_r;
  logic [31:0]        timeout_r;
  logic [CNT_W-1:0]   limit_r;

  // command latched at acceptance
  kind_t              kind_r;
  logic [PAY_W-1:0]   pay_r;
  logic               ended_r;
  logic [SEQ_W-1:0]   ack_r;
  logic [SEQ_W-1:0]   gs_r;
  logic [SEQ_W-1:0]   ge_r;

  // window state
  state_t             state_r, state_nxt;
  logic [SEQ_W-1:0]   ws_r, ws_nxt;
  logic [CNT_W-1:0]   inflight_r, inflight_nxt;
  logic [31:0]        idle_r, idle_nxt;
  logic               flag_r, flag_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  // walk state
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [ACKB_W-1:0]  sum_r, sum_nxt;
  logic               inwin_r, inwin_nxt;
  logic [PAY_W-1:0]   rd_q_r;

  // held resend, sent once the next one (or the end of the walk) is known
  logic               pend_valid_r, pend_valid_nxt;
  logic [SEQ_W-1:0]   pend_seq_r, pend_seq_nxt;
  logic [PAY_W-1:0]   pend_bytes_r, pend_bytes_nxt;
  logic [TOTAL_W-1:0] pend_total_r, pend_total_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;
  logic               out_load;
  logic               out_free;

  // slot length memory
  logic [PAY_W-1:0]   slot_mem [WIN_DEPTH];
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [PAY_W-1:0]   pay_sat;

  // shared subtractor and helpers
  logic [SEQ_W-1:0]   sub_a, sub_b, diff;
  logic [CNT_W-1:0]   win_lim;
  logic [CNT_W-1:0]   d_ack, d_gap, cnt_tick;
  logic [31:0]        idle_inc;
  logic               tick_fire;
  logic [PAY_W-1:0]   acc_len;
  logic [TOTAL_W-1:0] acc_sum;

  sws_total_acc u_acc (
    .total_i (total_r),
    .len_i   (acc_len),
    .sum_o   (acc_sum)
  );

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= WINDOW_RESET;
      timeout_r <= TIMEOUT_RESET;
      limit_r   <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_WINDOW:  window_r  <= cfg_data[CNT_W-1:0];
        REG_TIMEOUT: timeout_r <= cfg_data;
        REG_LIMIT:   limit_r   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // command capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r  <= kind_t'(in_tuser);
      pay_r   <= in_tdata[PAY_W-1:0];
      ended_r <= in_tlast;
      ack_r   <= in_tdata[PAY_W +: SEQ_W];
      gs_r    <= in_tdata[PAY_W + SEQ_W +: SEQ_W];
      ge_r    <= in_tdata[PAY_W + 2*SEQ_W +: SEQ_W];
    end
  end

  // slot memory: written for new packets, read one slot per walk step
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= pay_sat;
    end
    rd_q_r <= slot_mem[seq_r[SLOT_W-1:0]];
  end

  // one subtractor serves the ack distance, the gap length and the window check
  always_comb begin
    sub_a = seq_r;
    sub_b = ws_r;
    if (state_r == S_EXEC) begin
      if (kind_r == KIND_GAP) begin
        sub_a = ge_r;
        sub_b = gs_r;
      end else begin
        sub_a = ack_r;
        sub_b = ws_r;
      end
    end
  end
  assign diff = sub_a - sub_b;

  // ack distance: stale acks give zero, clamped to what is in flight
  always_comb begin
    if (diff[SEQ_W-1]) begin
      d_ack = '0;
    end else if (diff > {{(SEQ_W-CNT_W){1'b0}}, inflight_r}) begin
      d_ack = inflight_r;
    end else begin
      d_ack = diff[CNT_W-1:0];
    end
  end

  // gap length: empty or inverted ranges give zero, capped at the depth
  always_comb begin
    if (diff[SEQ_W-1]) begin
      d_gap = '0;
    end else if (diff > {{(SEQ_W-CNT_W){1'b0}}, DEPTH_CNT}) begin
      d_gap = DEPTH_CNT;
    end else begin
      d_gap = diff[CNT_W-1:0];
    end
  end

  // window register clamped to 1..depth
  always_comb begin
    if (window_r == '0) begin
      win_lim = CNT_W'(1);
    end else if (window_r > DEPTH_CNT) begin
      win_lim = DEPTH_CNT;
    end else begin
      win_lim = window_r;
    end
  end

  assign pay_sat   = (pay_r > PAY_LIMIT) ? PAY_LIMIT : pay_r;
  assign idle_inc  = (idle_r == '1) ? idle_r : idle_r + 32'd1;
  assign tick_fire = (idle_inc >= timeout_r);
  assign cnt_tick  = (limit_r > inflight_r) ? inflight_r : limit_r;
  assign mem_waddr = ws_r[SLOT_W-1:0] + inflight_r[SLOT_W-1:0];
  assign inwin_nxt = (diff < {{(SEQ_W-CNT_W){1'b0}}, inflight_r});

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ws_r         <= '0;
      inflight_r   <= '0;
      idle_r       <= '0;
      flag_r       <= 1'b0;
      total_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ws_r         <= ws_nxt;
      inflight_r   <= inflight_nxt;
      idle_r       <= idle_nxt;
      flag_r       <= flag_nxt;
      total_r      <= total_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r        <= seq_nxt;
    rem_r        <= rem_nxt;
    sum_r        <= sum_nxt;
    inwin_r      <= inwin_nxt;
    pend_seq_r   <= pend_seq_nxt;
    pend_bytes_r <= pend_bytes_nxt;
    pend_total_r <= pend_total_nxt;
    if (out_load) begin
      out_res_r <= out_res_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ws_nxt         = ws_r;
    inflight_nxt   = inflight_r;
    idle_nxt       = idle_r;
    flag_nxt       = flag_r;
    total_nxt      = total_r;
    seq_nxt        = seq_r;
    rem_nxt        = rem_r;
    sum_nxt        = sum_r;
    pend_valid_nxt = pend_valid_r;
    pend_seq_nxt   = pend_seq_r;
    pend_bytes_nxt = pend_bytes_r;
    pend_total_nxt = pend_total_r;
    mem_we         = 1'b0;
    acc_len        = (state_r == S_USE) ? rd_q_r : pay_sat;
    out_load       = 1'b0;
    out_res_nxt    = '0;
    out_res_nxt.total_sent_bytes = total_r;
    out_res_nxt.in_flight_count  = inflight_r;
    out_res_nxt.transfer_done    = flag_r && (inflight_r == '0);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        seq_nxt = ws_r;
        sum_nxt = '0;
        case (kind_r)
          KIND_NEW: begin
            if (out_free) begin
              out_load         = 1'b1;
              out_res_nxt.last = 1'b1;
              state_nxt        = S_IDLE;
              if (inflight_r < win_lim) begin
                mem_we       = 1'b1;
                total_nxt    = acc_sum;
                inflight_nxt = inflight_r + CNT_W'(1);
                flag_nxt     = flag_r || ended_r;
                out_res_nxt.send_valid       = 1'b1;
                out_res_nxt.send_seq         = ws_r + {{(SEQ_W-CNT_W){1'b0}}, inflight_r};
                out_res_nxt.send_bytes       = pay_sat;
                out_res_nxt.total_sent_bytes = acc_sum;
                out_res_nxt.in_flight_count  = inflight_nxt;
                out_res_nxt.transfer_done    = 1'b0;
              end else begin
                out_res_nxt.refused = 1'b1;
              end
            end
          end
          KIND_ACK: begin
            // window moves now; the walk reads from the old start kept in seq
            rem_nxt      = d_ack;
            ws_nxt       = ws_r + {{(SEQ_W-CNT_W){1'b0}}, d_ack};
            inflight_nxt = inflight_r - d_ack;
            if (d_ack != '0) begin
              idle_nxt  = '0;
              state_nxt = S_RD;
            end else begin
              state_nxt = S_FIN;
            end
          end
          KIND_GAP: begin
            seq_nxt   = gs_r;
            rem_nxt   = d_gap;
            state_nxt = (d_gap != '0) ? S_RD : S_FIN;
          end
          default: begin
            // tick
            if (tick_fire) begin
              idle_nxt  = '0;
              rem_nxt   = cnt_tick;
              state_nxt = (cnt_tick != '0) ? S_RD : S_FIN;
            end else begin
              idle_nxt  = idle_inc;
              state_nxt = S_FIN;
            end
          end
        endcase
      end

      S_RD: begin
        // memory read of slot seq_r and window check are registered here
        state_nxt = S_USE;
      end

      S_USE: begin
        if (kind_r == KIND_ACK) begin
          sum_nxt = sum_r + {{(ACKB_W-PAY_W){1'b0}}, rd_q_r};
          seq_nxt = seq_r + SEQ_W'(1);
          rem_nxt = rem_r - CNT_W'(1);
          state_nxt = (rem_r == CNT_W'(1)) ? S_FIN : S_RD;
        end else if (!inwin_r || !pend_valid_r || out_free) begin
          if (inwin_r) begin
            if (pend_valid_r) begin
              out_load                     = 1'b1;
              out_res_nxt.send_valid       = 1'b1;
              out_res_nxt.send_seq         = pend_seq_r;
              out_res_nxt.is_resend        = 1'b1;
              out_res_nxt.send_bytes       = pend_bytes_r;
              out_res_nxt.total_sent_bytes = pend_total_r;
            end
            pend_valid_nxt = 1'b1;
            pend_seq_nxt   = seq_r;
            pend_bytes_nxt = rd_q_r;
            pend_total_nxt = acc_sum;
            total_nxt      = acc_sum;
          end
          seq_nxt = seq_r + SEQ_W'(1);
          rem_nxt = rem_r - CNT_W'(1);
          state_nxt = (rem_r == CNT_W'(1)) ? S_FIN : S_RD;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_res_nxt.last = 1'b1;
          state_nxt        = S_IDLE;
          if (pend_valid_r) begin
            pend_valid_nxt               = 1'b0;
            out_res_nxt.send_valid       = 1'b1;
            out_res_nxt.send_seq         = pend_seq_r;
            out_res_nxt.is_resend        = 1'b1;
            out_res_nxt.send_bytes       = pend_bytes_r;
            out_res_nxt.total_sent_bytes = pend_total_r;
          end else if (kind_r == KIND_ACK) begin
            out_res_nxt.acked_bytes = sum_r;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // result channel packing
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.last;
  assign out_tuser  = {out_res_r.refused, out_res_r.is_resend, out_res_r.send_valid};
  assign out_tdata  = {6'b0,
                       out_res_r.transfer_done,
                       out_res_r.in_flight_count,
                       out_res_r.total_sent_bytes,
                       out_res_r.acked_bytes,
                       out_res_r.send_bytes,
                       out_res_r.send_seq};

`ifndef SYNTHESIS
  // the window never holds more packets than there are slots
  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= DEPTH_CNT)
    else $error("in-flight count beyond window depth");

  // a held resend is always flushed before the sequencer goes idle
  a_pend_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_valid_r)
    else $error("held resend left behind");

  // walk steps only run with slots left to visit
  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_USE) |-> (rem_r != '0))
    else $error("walk running with zero remaining");

  // an accepted command is dispatched on the next cycle
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EXEC))
    else $error("accepted command not dispatched");
`endif

endmodule

// ----- rtl/sws_total_acc.sv -----
// sws_total_acc: saturating byte total, adds a payload length plus one
// depends on sws_pkg
module sws_total_acc (
  input  logic [sws_pkg::TOTAL_W-1:0] total_i,
  input  logic [sws_pkg::PAY_W-1:0]   len_i,
  output logic [sws_pkg::TOTAL_W-1:0] sum_o
);
  import sws_pkg::*;

  logic [TOTAL_W:0] wide_sum;

  // carry out of the 48-bit add means the total passed its ceiling
  assign wide_sum = {1'b0, total_i} + {{(TOTAL_W - PAY_W + 1){1'b0}}, len_i}
                    + {{TOTAL_W{1'b0}}, 1'b1};
  assign sum_o    = wide_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : wide_sum[TOTAL_W-1:0];

endmodule

// ----- tb/sliding_window_sender_core_tb.sv -----
// sliding_window_sender_core_tb: self-checking bench for the sliding-window sender core
// a behavioral predictor of window, slot lengths, idle ticks and byte total checks every
// result transaction; depends on sws_pkg and sliding_window_sender_core
module sliding_window_sender_core_tb;
  import sws_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;

  // one command as offered on the input channel
  typedef struct {
    kind_t            kind;
    logic [PAY_W-1:0] pay;
    logic             ended;
    logic [31:0]      ack;
    logic [31:0]      gs;
    logic [31:0]      ge;
  } cmd_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  // register copies, reset values of the block
  logic [CNT_W-1:0]      window_reg  = 7'd45;
  logic [31:0]           timeout_reg = 32'd1000;
  logic [CNT_W-1:0]      limit_reg   = 7'd2;

  // sender state as the block should hold it
  logic [31:0]           window_base = '0;
  int unsigned           flight      = 0;
  logic [PAY_W-1:0]      slot_len [WIN_DEPTH];
  logic [31:0]           idle_count  = '0;
  logic                  ended_flag  = 1'b0;
  logic [TOTAL_W-1:0]    sent_total  = '0;

  // transmissions and status transactions still owed by the block, oldest first
  res_t                  sends_due [$];

  int unsigned           mismatches   = 0;
  int unsigned           results_seen = 0;
  int unsigned           cycle_count  = 0;
  int unsigned           hold_request = 0;
  bit                    tx_steady    = 1'b0;
  bit                    rx_steady    = 1'b0;

  sliding_window_sender_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // every send adds its length plus one, the total sticks at all ones
  function automatic void add_to_total(input logic [PAY_W-1:0] len);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, sent_total} + len + 1;
    sent_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  endfunction

  function automatic res_t resend_entry(input logic [31:0] seq);
    res_t r;
    r = '0;
    add_to_total(slot_len[seq % WIN_DEPTH]);
    r.send_valid       = 1'b1;
    r.send_seq         = seq;
    r.is_resend        = 1'b1;
    r.send_bytes       = slot_len[seq % WIN_DEPTH];
    r.total_sent_bytes = sent_total;
    return r;
  endfunction

  // works out the transactions one accepted command causes and queues them
  function automatic void apply_command(input cmd_t c);
    res_t        batch [$];
    res_t        r;
    logic [31:0] span;
    logic [31:0] seq;
    logic [31:0] offset;
    logic [15:0] acked;
    int unsigned w;
    int unsigned n;
    int unsigned i;
    r = '0;
    case (c.kind)
      KIND_NEW: begin
        // window register out of range acts as 1 or as the depth
        w = window_reg;
        if (w < 1) w = 1;
        if (w > WIN_DEPTH) w = WIN_DEPTH;
        if (flight < w) begin
          seq = window_base + flight;
          slot_len[seq % WIN_DEPTH] = c.pay;
          add_to_total(c.pay);
          flight++;
          if (c.ended) ended_flag = 1'b1;
          r.send_valid = 1'b1;
          r.send_seq   = seq;
          r.send_bytes = c.pay;
        end else begin
          // full window: nothing stored, end of source not taken
          r.refused = 1'b1;
        end
        r.total_sent_bytes = sent_total;
        batch.push_back(r);
      end
      KIND_ACK: begin
        // stale acks move nothing, acks past the window clamp to it
        span = c.ack - window_base;
        if (span[31]) span = '0;
        if (span > flight) span = flight;
        acked = '0;
        for (i = 0; i < span; i++) acked += slot_len[(window_base + i) % WIN_DEPTH];
        if (span != 0) begin
          window_base += span;
          flight      -= span;
          idle_count   = '0;
        end
        r.acked_bytes      = acked;
        r.total_sent_bytes = sent_total;
        batch.push_back(r);
      end
      KIND_GAP: begin
        // inverted range is empty, wide range capped at the depth
        span = c.ge - c.gs;
        if (span[31]) span = '0;
        if (span > WIN_DEPTH) span = WIN_DEPTH;
        for (i = 0; i < span; i++) begin
          seq    = c.gs + i;
          offset = seq - window_base;
          if (offset < flight) batch.push_back(resend_entry(seq));
        end
      end
      default: begin
        if (idle_count != '1) idle_count++;
        if (idle_count >= timeout_reg) begin
          n = limit_reg;
          if (n > flight) n = flight;
          for (i = 0; i < n; i++) batch.push_back(resend_entry(window_base + i));
          idle_count = '0;
        end
      end
    endcase
    if (batch.size() == 0) begin
      r = '0;
      r.total_sent_bytes = sent_total;
      batch.push_back(r);
    end
    // window count and done flag are the ones after the whole command
    foreach (batch[k]) begin
      batch[k].in_flight_count = flight[CNT_W-1:0];
      batch[k].transfer_done   = ended_flag && (flight == 0);
      batch[k].last            = (k == batch.size() - 1);
      sends_due.push_back(batch[k]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%s", msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("transaction %0d %s: got 0x%0h, want 0x%0h",
                                results_seen, name, got, want));
  endtask

  task automatic check_transmission(input res_t got);
    res_t want;
    results_seen++;
    if (sends_due.size() == 0) begin
      report_mismatch($sformatf("transaction %0d: none was due", results_seen));
      return;
    end
    want = sends_due.pop_front();
    compare_field("send_valid", got.send_valid, want.send_valid);
    compare_field("send_seq", got.send_seq, want.send_seq);
    compare_field("is_resend", got.is_resend, want.is_resend);
    compare_field("send_bytes", got.send_bytes, want.send_bytes);
    compare_field("refused", got.refused, want.refused);
    compare_field("acked_bytes", got.acked_bytes, want.acked_bytes);
    compare_field("total_sent_bytes", got.total_sent_bytes, want.total_sent_bytes);
    compare_field("in_flight_count", got.in_flight_count, want.in_flight_count);
    compare_field("transfer_done", got.transfer_done, want.transfer_done);
    compare_field("last", got.last, want.last);
  endtask

  // unpack each accepted result transaction, sampled at the rising edge
  always @(posedge clk) begin : watch_results
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.send_valid       = out_tuser[0];
      got.is_resend        = out_tuser[1];
      got.refused          = out_tuser[2];
      got.send_seq         = out_tdata[31:0];
      got.send_bytes       = out_tdata[41:32];
      got.acked_bytes      = out_tdata[57:42];
      got.total_sent_bytes = out_tdata[105:58];
      got.in_flight_count  = out_tdata[112:106];
      got.transfer_done    = out_tdata[113];
      got.last             = out_tlast;
      check_transmission(got);
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, a few long ones, and the requested long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        // long hold-off counted here so the sender keeps offering meanwhile
        out_tready <= 1'b0;
        repeat (hold_request - 1) @(negedge clk);
        hold_request = 0;
      end else if (!rx_steady && $urandom_range(0, 99) < 3) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 40) - 1) @(negedge clk);
      end else begin
        out_tready <= rx_steady || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sliding_window_sender_core: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // sender gap in cycles: mostly none, often short, rarely long
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cmd_t make_cmd(input kind_t kind, input logic [PAY_W-1:0] pay,
                                    input logic ended, input logic [31:0] ack,
                                    input logic [31:0] gs, input logic [31:0] ge);
    cmd_t c;
    c.kind  = kind;
    c.pay   = pay;
    c.ended = ended;
    c.ack   = ack;
    c.gs    = gs;
    c.ge    = ge;
    return c;
  endfunction

  // random command, mostly aimed at the live window, the rest broken or noise;
  // fields a kind ignores still carry random bits
  function automatic cmd_t pick_command();
    cmd_t        c;
    int unsigned roll;
    c.pay   = PAY_W'($urandom);
    c.ended = ($urandom_range(0, 49) == 0);
    c.ack   = $urandom;
    c.gs    = $urandom;
    c.ge    = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      c.kind = KIND_NEW;
      roll = $urandom_range(0, 9);
      if (roll == 0) c.pay = '0;
      else if (roll == 1) c.pay = '1;
    end else if (roll < 60) begin
      c.kind = KIND_ACK;
      roll = $urandom_range(0, 9);
      if (roll < 7) c.ack = window_base + $urandom_range(0, flight);
      else if (roll == 7) c.ack = window_base + flight + $urandom_range(1, 100);
      else if (roll == 8) c.ack = window_base - $urandom_range(1, 100);
    end else if (roll < 75) begin
      c.kind = KIND_GAP;
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        c.gs = window_base + $urandom_range(0, flight);
        c.ge = c.gs + $urandom_range(0, 6);
      end else if (roll == 7) begin
        // wide range reaching below the window, capped at the depth
        c.gs = window_base - $urandom_range(0, 70);
        c.ge = c.gs + $urandom_range(60, 200);
      end else if (roll == 8) begin
        c.ge = c.gs - $urandom_range(0, 5);
      end
    end else begin
      c.kind = KIND_TICK;
    end
    return c;
  endfunction

  // one command transaction; valid stays high across back-to-back commands
  task automatic send_command(input cmd_t c);
    int unsigned gap;
    gap = tx_steady ? 0 : idle_length();
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, c.ge, c.gs, c.ack, c.pay};
    in_tuser  <= c.kind;
    in_tlast  <= c.ended;
    do @(posedge clk); while (!in_tready);
    apply_command(c);
  endtask

  // stop offering and wait until every owed transaction has come out
  task automatic settle(input int unsigned extra);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sends_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WINDOW:  window_reg  = value[CNT_W-1:0];
      REG_TIMEOUT: timeout_reg = value;
      REG_LIMIT:   limit_reg   = value[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // registers change only once the block has drained
  task automatic configure(input logic [CNT_W-1:0] win, input logic [31:0] ticks,
                           input logic [CNT_W-1:0] lim);
    settle(12);
    write_register(REG_WINDOW, {25'd0, win});
    write_register(REG_TIMEOUT, ticks);
    write_register(REG_LIMIT, {25'd0, lim});
  endtask

  // random stretch, with runs where one side or both never idle
  task automatic run_mix(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if (k % 20 == 0) begin
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady = ($urandom_range(0, 4) == 0);
      end
      send_command(pick_command());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // window register 0 acts as 1; an end-of-source mark on a refused packet is dropped
  task automatic test_window_clamp();
    configure(7'd0, 32'd1000, 7'd2);
    send_command(make_cmd(KIND_NEW, 10'd7, 1'b0, '0, '0, '0));
    send_command(make_cmd(KIND_NEW, 10'd8, 1'b1, '0, '0, '0));
    send_command(make_cmd(KIND_ACK, '0, 1'b0, window_base + 1, '0, '0));
  endtask

  // field extremes, every kind and the ack and gap corner cases
  task automatic test_directed();
    configure(7'd45, 32'd1000, 7'd2);
    send_command(make_cmd(KIND_NEW, 10'd0, 1'b0, '0, '0, '0));
    send_command(make_cmd(KIND_NEW, 10'h3FF, 1'b0, '0, '0, '0));
    send_command(make_cmd(KIND_NEW, 10'h2AA, 1'b0, '0, '0, '0));
    send_command(make_cmd(KIND_NEW, 10'h155, 1'b0, '0, '0, '0));
    // stale ack, partial ack, ack far past the window
    send_command(make_cmd(KIND_ACK, '0, 1'b0, window_base - 1, '0, '0));
    send_command(make_cmd(KIND_ACK, '0, 1'b0, window_base + 1, '0, '0));
    send_command(make_cmd(KIND_ACK, '0, 1'b0, 32'h7FFF_FFFF, '0, '0));
    send_command(make_cmd(KIND_TICK, '0, 1'b0, '0, '0, '0));
    send_command(make_cmd(KIND_NEW, 10'd17, 1'b0, '0, '0, '0));
    send_command(make_cmd(KIND_NEW, 10'd300, 1'b0, '0, '0, '0));
    send_command(make_cmd(KIND_NEW, 10'd5, 1'b0, '0, '0, '0));
    // empty gap, inverted gap, gap hanging over both ends of the window
    send_command(make_cmd(KIND_GAP, '0, 1'b0, '0, window_base + 1, window_base + 1));
    send_command(make_cmd(KIND_GAP, '0, 1'b0, '0, window_base + 2, window_base));
    send_command(make_cmd(KIND_GAP, '0, 1'b0, '0, window_base - 1, window_base + 4));
    // huge gap capped at the depth, then one far away from the window
    send_command(make_cmd(KIND_GAP, '0, 1'b0, '0, window_base - 10,
                          window_base - 10 + 32'h7FFF_FFFF));
    send_command(make_cmd(KIND_GAP, '0, 1'b0, '0, 32'h8000_0000, 32'hFFFF_FFFF));
    send_command(make_cmd(KIND_ACK, '0, 1'b0, window_base + 1, '0, '0));
    // end of source, then one more packet after it
    send_command(make_cmd(KIND_NEW, 10'd9, 1'b1, '0, '0, '0));
    send_command(make_cmd(KIND_NEW, 10'd10, 1'b0, '0, '0, '0));
    send_command(make_cmd(KIND_ACK, '0, 1'b0, window_base - 5, '0, '0));
    send_command(make_cmd(KIND_ACK, '0, 1'b0, window_base + flight, '0, '0));
    send_command(make_cmd(KIND_TICK, '0, 1'b0, '0, '0, '0));
  endtask

  task automatic test_reset_settings_mix();
    run_mix(80);
  endtask

  // window above the depth, timeout on every tick, resend limit above the depth
  task automatic test_wide_window();
    configure(7'd127, 32'd1, 7'd127);
    run_mix(70);
  endtask

  // smallest window, zero timeout, zero resend limit
  task automatic test_tight_settings();
    configure(7'd0, 32'd0, 7'd0);
    run_mix(40);
  endtask

  task automatic test_mid_settings();
    configure(7'd8, 32'd3, 7'd5);
    run_mix(70);
  endtask

  // long receiver hold-off while commands keep coming, so the input stalls
  task automatic test_backpressure();
    configure(7'd64, 32'hFFFF_FFFF, 7'd1);
    hold_request = 300;
    tx_steady    = 1'b1;
    repeat (15) send_command(pick_command());
    tx_steady = 1'b0;
    settle(12);
    run_mix(50);
  endtask

  task automatic test_fast_timeout();
    configure(7'd20, 32'd2, 7'd64);
    run_mix(65);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr  = REG_WINDOW;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_window_clamp();
    test_directed();
    test_reset_settings_mix();
    test_wide_window();
    test_tight_settings();
    test_mid_settings();
    test_backpressure();
    test_fast_timeout();

    // drain, then leave room for any stray transaction to show up
    settle(150);
    if (mismatches == 0) begin
      $display("sliding_window_sender_core: match");
    end else begin
      $display("sliding_window_sender_core: mismatch");
    end
    $finish;
  end

endmodule
